/* hdl/thermal_core_tracker_assert.svh */
// assertion macros for the thermal core tracker
`ifndef THERMAL_CORE_TRACKER_ASSERT_SVH
`define THERMAL_CORE_TRACKER_ASSERT_SVH

// a implies b on the same edge
`define TCT_ASSERT_IMPL(label, rst_n, a, b) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (b)) \
		else $error("implication failed");

// a implies b on the next edge
`define TCT_ASSERT_NEXT(label, rst_n, a, b) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (b)) \
		else $error("next-cycle implication failed");

`endif

/* hdl/tct_pkg.sv */
`timescale 1ns / 1ps
package tct_pkg;
	typedef enum logic [2:0] {
		ST_IDLE,
		ST_SCAN,
		ST_START,
		ST_DIV,
		ST_OUT
	} state_t;

	localparam int MIN_POINTS = 3;

	typedef enum logic {
		OP_TICK  = 1'b0,
		OP_CLEAR = 1'b1
	} op_t;

	localparam logic CFG_MIN_CLIMB = 1'b0;
	localparam logic CFG_TIMEOUT   = 1'b1;

	// one history point as it moves along the row
	typedef struct packed {
		logic signed [30:0] lat;
		logic signed [31:0] lon;
		logic signed [20:0] alt;
		logic signed [15:0] climb;
		logic [31:0]        stamp;
	} point_t;
endpackage

/* hdl/tct_cell.sv */
`timescale 1ns / 1ps
// one history slot: loads on its write strobe, otherwise takes the neighbor
// value while the row rotates, so slot contents come past the head in order
module tct_cell (
	input  logic            clk,
	input  logic            load,
	input  logic            shift,
	input  tct_pkg::point_t wr_point,
	input  tct_pkg::point_t prev_point,
	output tct_pkg::point_t point
);
	tct_pkg::point_t point_q;

	always_ff @(posedge clk) begin
		if (load) begin
			point_q <= wr_point;
		end else if (shift) begin
			point_q <= prev_point;
		end
	end

	assign point = point_q;
endmodule

/* hdl/tct_divider.sv */
`timescale 1ns / 1ps
// restoring divider, one quotient bit a cycle, truncates toward zero
module tct_divider #(
	parameter int NW = 24,
	parameter int DW = 9
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 start,
	input  logic signed [NW-1:0] num,
	input  logic [DW-1:0]        den,
	output logic                 done,
	output logic signed [NW-1:0] quot
);
	localparam int CW = $clog2(NW + 1);
	logic [NW-1:0] mag_q;
	logic [NW-1:0] rem_q;
	logic [DW-1:0] den_q;
	logic          neg_q;
	logic [CW-1:0] cnt_q;
	logic          busy_q;
	logic [NW:0]   trial;

	assign trial = {rem_q, mag_q[NW-1]} - {{(NW + 1 - DW){1'b0}}, den_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done   <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= CW'(NW);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == CW'(1)) begin
					busy_q <= 1'b0;
					done   <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			neg_q <= num[NW-1];
			mag_q <= num[NW-1] ? NW'(-num) : NW'(num);
			rem_q <= '0;
			den_q <= den;
		end else if (busy_q) begin
			if (!trial[NW]) begin
				rem_q <= trial[NW-1:0];
				mag_q <= {mag_q[NW-2:0], 1'b1};
			end else begin
				rem_q <= {rem_q[NW-2:0], mag_q[NW-1]};
				mag_q <= {mag_q[NW-2:0], 1'b0};
			end
		end
	end

	assign quot = neg_q ? NW'(-mag_q) : mag_q;
endmodule

/* hdl/thermal_core_tracker.sv */
`timescale 1ns / 1ps
// per request after the accepting edge: the cell row rotates once through its
// HISTORY_DEPTH cells (ST_SCAN), the divider is started (ST_START) and divides (ST_DIV),
// then the output register is loaded (ST_OUT); with an empty store no division runs.
// A new request is taken only in ST_IDLE, once the last one is through;
// a result waiting on m_tready in the output register does not block new requests
// reset: arst_n clears counters, flags and state; history cells are not reset
`include "thermal_core_tracker_assert.svh"
module thermal_core_tracker #(
	parameter int HISTORY_DEPTH = 32
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_tvalid,
	output logic         s_tready,
	// op
	input  logic [0:0]   s_tuser,
	// time_ms, climb_rate, gps_valid, latitude, longitude, altitude
	input  logic [135:0] s_tdata,
	output logic         m_tvalid,
	input  logic         m_tready,
	// rising, core_valid, core_lat, core_lon, core_alt, time_since_core,
	// point_count, avg_climb
	output logic [143:0] m_tdata,
	input  logic         cfg_we,
	input  logic [0:0]   cfg_index,
	input  logic [31:0]  cfg_data
);
	localparam int SW = $clog2(HISTORY_DEPTH);
	localparam int FW = $clog2(HISTORY_DEPTH + 1);
	localparam int NW = 16 + FW + 1;

	logic signed [15:0] min_climb_q;
	logic [31:0]        timeout_q;
	tct_pkg::state_t    state_q, state_d;
	logic [SW-1:0]      wslot_q;
	logic [FW-1:0]      fill_q;
	logic [FW-1:0]      scan_q;
	logic               rising_q, held_q, pick_q;
	tct_pkg::point_t    core_q, best_q;
	logic [31:0]        now_q;
	logic signed [NW-1:0] sum_q;
	logic [143:0]       out_q;
	logic               out_v_q;

	logic [31:0]        in_time;
	logic signed [15:0] in_climb;
	logic               in_gps;
	tct_pkg::point_t    in_pt;
	logic               accept, tick, store;

	assign in_time  = s_tdata[31:0];
	assign in_climb = s_tdata[47:32];
	assign in_gps   = s_tdata[48];
	assign in_pt    = {s_tdata[79:49], s_tdata[111:80], s_tdata[132:112],
		s_tdata[47:32], s_tdata[31:0]};
	assign s_tready = (state_q == tct_pkg::ST_IDLE);
	assign accept   = s_tvalid && s_tready;
	assign tick     = accept && (s_tuser[0] == tct_pkg::OP_TICK);
	assign store    = tick && in_gps && (in_climb >= min_climb_q);

	// cell row, rotated once around during the scan
	tct_pkg::point_t pts [HISTORY_DEPTH];
	logic rotate;
	assign rotate = (state_q == tct_pkg::ST_SCAN);
	for (genvar g = 0; g < HISTORY_DEPTH; g++) begin : g_row
		tct_cell u_cell (
			.clk       (clk),
			.load      (store && (wslot_q == SW'(g))),
			.shift     (rotate),
			.wr_point  (in_pt),
			.prev_point(pts[(g + 1) % HISTORY_DEPTH]),
			.point     (pts[g])
		);
	end

	logic div_start, div_done;
	logic signed [NW-1:0] quot;
	tct_divider #(.NW(NW), .DW(FW)) u_div (
		.clk   (clk),
		.arst_n(arst_n),
		.start (div_start),
		.num   (sum_q),
		.den   (fill_q),
		.done  (div_done),
		.quot  (quot)
	);

	logic scan_last;
	assign scan_last = (scan_q == FW'(HISTORY_DEPTH - 1));

	// head cell holds slot scan_q during rotation
	logic head_in;
	tct_pkg::point_t best_d;
	assign head_in = (scan_q < fill_q);
	assign best_d  = ((scan_q == '0) || (head_in && (pts[0].climb > best_q.climb))) ?
		pts[0] : best_q;

	// output register is free when empty or being read this cycle
	logic out_free, load_out;
	assign out_free = !out_v_q || m_tready;
	assign load_out = (state_q == tct_pkg::ST_OUT) && out_free;

	always_comb begin
		state_d   = state_q;
		div_start = 1'b0;
		case (state_q)
			tct_pkg::ST_IDLE: if (accept) state_d = tct_pkg::ST_SCAN;
			tct_pkg::ST_SCAN: begin
				if (scan_last) begin
					if (fill_q != '0) begin
						state_d = tct_pkg::ST_START;
					end else begin
						state_d = tct_pkg::ST_OUT;
					end
				end
			end
			tct_pkg::ST_START: begin
				state_d   = tct_pkg::ST_DIV;
				div_start = 1'b1;
			end
			tct_pkg::ST_DIV:  if (div_done) state_d = tct_pkg::ST_OUT;
			tct_pkg::ST_OUT:  if (out_free) state_d = tct_pkg::ST_IDLE;
			default:          state_d = tct_pkg::ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= tct_pkg::ST_IDLE;
			min_climb_q <= 16'sd50;
			timeout_q   <= 32'd60000;
			wslot_q     <= '0;
			fill_q      <= '0;
			rising_q    <= 1'b0;
			held_q      <= 1'b0;
			pick_q      <= 1'b0;
			out_v_q     <= 1'b0;
			scan_q      <= '0;
			core_q      <= '0;
		end else begin
			state_q <= state_d;
			if (cfg_we) begin
				if (cfg_index == tct_pkg::CFG_MIN_CLIMB) min_climb_q <= cfg_data[15:0];
				else timeout_q <= cfg_data;
			end
			if (load_out) out_v_q <= 1'b1;
			else if (m_tvalid && m_tready) out_v_q <= 1'b0;
			if (accept) begin
				scan_q <= '0;
				if (!tick) begin
					wslot_q  <= '0;
					fill_q   <= '0;
					held_q   <= 1'b0;
					rising_q <= 1'b0;
					pick_q   <= 1'b0;
				end else begin
					if (held_q && ((in_time - core_q.stamp) > timeout_q)) held_q <= 1'b0;
					rising_q <= in_climb >= min_climb_q;
					pick_q   <= 1'b0;
					if (store) begin
						wslot_q <= (wslot_q == SW'(HISTORY_DEPTH - 1)) ? '0 : wslot_q + 1'b1;
						if (fill_q != FW'(HISTORY_DEPTH)) fill_q <= fill_q + 1'b1;
						pick_q <= (fill_q >= FW'(tct_pkg::MIN_POINTS - 1));
					end
				end
			end
			if (rotate) begin
				scan_q <= scan_q + 1'b1;
				if (scan_last && pick_q) begin
					core_q <= best_d;
					held_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) now_q <= in_time;
		if (rotate) begin
			best_q <= best_d;
			if (scan_q == '0) begin
				sum_q <= head_in ? NW'(pts[0].climb) : '0;
			end else if (head_in) begin
				sum_q <= sum_q + NW'(pts[0].climb);
			end
		end
		if (load_out) begin
			out_q[0]       <= rising_q;
			out_q[1]       <= held_q;
			out_q[32:2]    <= held_q ? core_q.lat : '0;
			out_q[64:33]   <= held_q ? core_q.lon : '0;
			out_q[85:65]   <= held_q ? core_q.alt : '0;
			out_q[117:86]  <= held_q ? now_q - core_q.stamp : '0;
			out_q[123:118] <= 6'(fill_q);
			out_q[139:124] <= (fill_q == '0) ? 16'sd0 : quot[15:0];
			out_q[143:140] <= '0;
		end
	end

	assign m_tvalid = out_v_q;
	assign m_tdata  = out_q;

	`TCT_ASSERT_IMPL(a_fill_range, arst_n, 1'b1, fill_q <= FW'(HISTORY_DEPTH))
	`TCT_ASSERT_IMPL(a_no_accept_busy, arst_n, state_q != tct_pkg::ST_IDLE, !s_tready)
	`TCT_ASSERT_NEXT(a_out_follows, arst_n, state_q == tct_pkg::ST_OUT, m_tvalid)
endmodule
